>>> design/dcf_pkg.sv
`timescale 1ns / 1ps

package dcf_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned WDOG_W  = 9;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned FRAME_W = 58;
  localparam int unsigned CFG_IDX_W = 3;

  // status codes
  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // input function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PULSE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_ABOVE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [DUR_W-1:0]  ONE_LOW_MIN_RST    = 16'd750;
  localparam logic [DUR_W-1:0]  ZERO_LOW_MIN_RST   = 16'd850;
  localparam logic [DUR_W-1:0]  ZERO_LOW_MAX_RST   = 16'd950;
  localparam logic [DUR_W-1:0]  MARKER_ABOVE_RST   = 16'd1500;
  localparam logic [WDOG_W-1:0] WATCHDOG_LIMIT_RST = 9'd300;

  localparam logic [WDOG_W-1:0] COUNT_MAX  = 9'd511;
  localparam logic [IDX_W-1:0]  FRAME_DONE = 6'd58;

  // frame bit positions
  localparam int unsigned MIN_LSB  = 21;
  localparam int unsigned HOUR_LSB = 29;
  localparam int unsigned DAY_LSB  = 36;
  localparam int unsigned WDAY_LSB = 42;
  localparam int unsigned MON_LSB  = 45;
  localparam int unsigned YEAR_LSB = 50;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [5:0] mday;
    logic [2:0] wday;
    logic [4:0] month_num;
    logic [7:0] year_two_digit;
  } dcf_time_t;

  // units weigh 1,2,4,8; tens weigh 10,20,40,80
  function automatic logic [7:0] bcd_val(input logic [3:0] units, input logic [3:0] tens);
    bcd_val = {4'b0, units} + {1'b0, tens, 3'b0} + {3'b0, tens, 1'b0};
  endfunction

endpackage

>>> design/dcf_decode.sv
`timescale 1ns / 1ps

module dcf_decode (
  input  logic [dcf_pkg::FRAME_W-1:0] frame,
  output dcf_pkg::dcf_time_t          tm
);

  logic [7:0] mi, hr, dm, mo, yr;
  logic [2:0] wd;
  logic       in_range;

  assign mi = dcf_pkg::bcd_val(frame[dcf_pkg::MIN_LSB +: 4],
                               {1'b0, frame[dcf_pkg::MIN_LSB+4 +: 3]});
  assign hr = dcf_pkg::bcd_val(frame[dcf_pkg::HOUR_LSB +: 4],
                               {2'b0, frame[dcf_pkg::HOUR_LSB+4 +: 2]});
  assign dm = dcf_pkg::bcd_val(frame[dcf_pkg::DAY_LSB +: 4],
                               {2'b0, frame[dcf_pkg::DAY_LSB+4 +: 2]});
  assign wd = frame[dcf_pkg::WDAY_LSB +: 3];
  assign mo = dcf_pkg::bcd_val(frame[dcf_pkg::MON_LSB +: 4],
                               {3'b0, frame[dcf_pkg::MON_LSB+4]});
  assign yr = dcf_pkg::bcd_val(frame[dcf_pkg::YEAR_LSB +: 4],
                               frame[dcf_pkg::YEAR_LSB+4 +: 4]);

  // weekday always fits in three bits, so it needs no check
  assign in_range = (mi < 8'd60) && (hr < 8'd24) && (dm <= 8'd31) &&
                    (mo <= 8'd12) && (yr < 8'd100);

  always_comb begin
    tm.status         = in_range ? dcf_pkg::STATUS_VALID : dcf_pkg::STATUS_RANGE;
    tm.minutes        = mi[6:0];
    tm.hours          = hr[5:0];
    tm.mday           = dm[5:0];
    tm.wday           = wd;
    tm.month_num      = mo[4:0];
    tm.year_two_digit = yr;
  end

endmodule

>>> design/dcf77_time_frame_decoder.sv
`timescale 1ns / 1ps
// A result reaches out_* through the input register, then classification, frame
// update and BCD decode into the result register. Throughput: one beat per cycle
// while the result side takes its beats; the shared state is computed
// combinationally, so the loop adds no stall of its own.
// Reset (rst_n low, synchronous): session closed, frame and counters cleared,
// thresholds back to 750/850/950/1500 ms and watchdog limit 300.
module dcf77_time_frame_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [15:0]                        in_low_duration,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [6:0]                         out_minutes,
  output logic [5:0]                         out_hours,
  output logic [5:0]                         out_mday,
  output logic [2:0]                         out_wday,
  output logic [4:0]                         out_month_num,
  output logic [7:0]                         out_year_two_digit,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_wdata
);

  // configuration
  logic [dcf_pkg::DUR_W-1:0]  one_low_min_r, zero_low_min_r, zero_low_max_r, marker_above_r;
  logic [dcf_pkg::WDOG_W-1:0] watchdog_limit_r;

  // input register
  logic                       s1_valid_r;
  logic                       s1_func_r;
  logic [dcf_pkg::DUR_W-1:0]  s1_dur_r;

  // decoder state
  logic                        session_r, session_nxt;
  logic [dcf_pkg::IDX_W-1:0]   bit_index_r, bit_index_nxt;
  logic                        index_valid_r, index_valid_nxt;
  logic [dcf_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [dcf_pkg::WDOG_W-1:0]  count_r, count_nxt;

  // result register
  logic               out_valid_r;
  dcf_pkg::dcf_time_t out_r, res_nxt;
  logic               res_fire;

  dcf_pkg::dcf_time_t dec;
  logic               advance;
  logic               is_marker, is_one, is_zero, timeout;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_low_min_r    <= dcf_pkg::ONE_LOW_MIN_RST;
      zero_low_min_r   <= dcf_pkg::ZERO_LOW_MIN_RST;
      zero_low_max_r   <= dcf_pkg::ZERO_LOW_MAX_RST;
      marker_above_r   <= dcf_pkg::MARKER_ABOVE_RST;
      watchdog_limit_r <= dcf_pkg::WATCHDOG_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcf_pkg::REG_ONE_LOW_MIN:    one_low_min_r    <= cfg_wdata;
        dcf_pkg::REG_ZERO_LOW_MIN:   zero_low_min_r   <= cfg_wdata;
        dcf_pkg::REG_ZERO_LOW_MAX:   zero_low_max_r   <= cfg_wdata;
        dcf_pkg::REG_MARKER_ABOVE:   marker_above_r   <= cfg_wdata;
        dcf_pkg::REG_WATCHDOG_LIMIT: watchdog_limit_r <= cfg_wdata[dcf_pkg::WDOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func_r <= in_func;
      s1_dur_r  <= in_low_duration;
    end
  end

  assign is_marker = s1_dur_r > marker_above_r;
  assign is_one    = (s1_dur_r >= one_low_min_r) && (s1_dur_r < zero_low_min_r);
  assign is_zero   = (s1_dur_r >= zero_low_min_r) && (s1_dur_r < zero_low_max_r);

  always_comb begin
    session_nxt     = session_r;
    bit_index_nxt   = bit_index_r;
    index_valid_nxt = index_valid_r;
    frame_nxt       = frame_r;
    count_nxt       = count_r;
    timeout         = 1'b0;
    res_fire        = 1'b0;
    res_nxt         = dec;
    if (s1_func_r == dcf_pkg::FUNC_START) begin
      session_nxt     = 1'b1;
      bit_index_nxt   = '0;
      index_valid_nxt = 1'b0;
      frame_nxt       = '0;
      count_nxt       = '0;
    end else if (session_r) begin
      if (is_marker) begin
        bit_index_nxt   = '0;
        index_valid_nxt = 1'b1;
        frame_nxt       = '0;
      end else if (index_valid_r) begin
        if (is_one) begin
          frame_nxt     = frame_r | ({{(dcf_pkg::FRAME_W-1){1'b0}}, 1'b1} << bit_index_r);
          bit_index_nxt = bit_index_r + 1'b1;
        end else if (is_zero) begin
          bit_index_nxt = bit_index_r + 1'b1;
        end else begin
          index_valid_nxt = 1'b0;
        end
      end
      if (count_r != dcf_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      timeout = count_nxt > watchdog_limit_r;
      if (timeout) begin
        session_nxt    = 1'b0;
        res_fire       = 1'b1;
        res_nxt        = '0;
        res_nxt.status = dcf_pkg::STATUS_TIMEOUT;
      end else if (index_valid_nxt && bit_index_nxt == dcf_pkg::FRAME_DONE) begin
        session_nxt = 1'b0;
        res_fire    = 1'b1;
      end
    end
  end

  dcf_decode u_decode (
    .frame (frame_nxt),
    .tm    (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r     <= 1'b0;
      bit_index_r   <= '0;
      index_valid_r <= 1'b0;
      frame_r       <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        session_r     <= session_nxt;
        bit_index_r   <= bit_index_nxt;
        index_valid_r <= index_valid_nxt;
        frame_r       <= frame_nxt;
        count_r       <= count_nxt;
      end
      // drop the held beat once taken; load a new one when this item emits
      if (advance && res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_minutes        = out_r.minutes;
  assign out_hours          = out_r.hours;
  assign out_mday           = out_r.mday;
  assign out_wday           = out_r.wday;
  assign out_month_num      = out_r.month_num;
  assign out_year_two_digit = out_r.year_two_digit;

endmodule

>>> design/dcf_chk.sv
`timescale 1ns / 1ps

module dcf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [6:0] out_minutes,
  input logic [5:0] out_hours,
  input logic [5:0] out_mday,
  input logic [2:0] out_wday,
  input logic [4:0] out_month_num,
  input logic [7:0] out_year_two_digit
);

  logic fields_ok;
  assign fields_ok = (out_minutes < 7'd60) && (out_hours < 6'd24) &&
                     (out_mday <= 6'd31) && (out_month_num <= 5'd12) &&
                     (out_year_two_digit < 8'd100);

  // a held result beat stays valid and keeps its status and minutes until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_minutes))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == dcf_pkg::STATUS_VALID) ||
                  (out_status == dcf_pkg::STATUS_RANGE) ||
                  (out_status == dcf_pkg::STATUS_TIMEOUT))
    else $error("undefined status code");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dcf_pkg::STATUS_TIMEOUT |->
      out_minutes == '0 && out_hours == '0 && out_mday == '0 &&
      out_wday == '0 && out_month_num == '0 && out_year_two_digit == '0)
    else $error("timeout result carries nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dcf_pkg::STATUS_VALID |-> fields_ok)
    else $error("valid status with field out of range");

  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dcf_pkg::STATUS_RANGE |-> !fields_ok)
    else $error("range status with all fields in range");

endmodule

bind dcf77_time_frame_decoder dcf_chk u_dcf_chk (.*);

>>> dv/dcf77_time_frame_decoder_tb.sv
`timescale 1ns / 1ps

module dcf77_time_frame_decoder_tb;

  localparam int ITEM_GOAL   = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 20;

  localparam dcf_pkg::dcf_time_t NO_TIME   = '0;
  localparam dcf_pkg::dcf_time_t TIMED_OUT = '{status: dcf_pkg::STATUS_TIMEOUT, default: '0};

  typedef struct packed {
    logic      func;
    logic [15:0] dur;
    logic      typed;
    dcf_pkg::dcf_time_t want;
  } beat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [15:0] in_low_duration = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [6:0] out_minutes;
  logic [5:0] out_hours;
  logic [5:0] out_mday;
  logic [2:0] out_wday;
  logic [4:0] out_month_num;
  logic [7:0] out_year_two_digit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // decoder shadow: thresholds and frame state
  logic [15:0] one_min_ms  = dcf_pkg::ONE_LOW_MIN_RST;
  logic [15:0] zero_min_ms = dcf_pkg::ZERO_LOW_MIN_RST;
  logic [15:0] zero_max_ms = dcf_pkg::ZERO_LOW_MAX_RST;
  logic [15:0] marker_ms   = dcf_pkg::MARKER_ABOVE_RST;
  logic [dcf_pkg::WDOG_W-1:0] pulse_limit = dcf_pkg::WATCHDOG_LIMIT_RST;
  logic in_session = 1'b0;
  logic [dcf_pkg::IDX_W-1:0] next_bit = '0;
  logic locked = 1'b0;
  logic [63:0] rx_frame = '0;
  logic [dcf_pkg::WDOG_W-1:0] pulse_total = '0;

  dcf_pkg::dcf_time_t expected_times [$];
  dcf_pkg::dcf_time_t head_time;
  beat_row_t directed_rows [DIR_ROWS];

  int err_count = 0;
  int live_items = 0;
  int times_due = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int sink_hold_req = 0;

  dcf77_time_frame_decoder u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_low_duration    (in_low_duration),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_minutes        (out_minutes),
    .out_hours          (out_hours),
    .out_mday           (out_mday),
    .out_wday           (out_wday),
    .out_month_num      (out_month_num),
    .out_year_two_digit (out_year_two_digit),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // units weigh 1,2,4,8 and tens 10,20,40,80
  function automatic int unsigned field_value(input int lsb, input int n);
    int unsigned acc;
    acc = 0;
    for (int k = 0; k < n; k++)
      if (rx_frame[lsb + k]) acc += (k < 4) ? (1 << k) : (10 << (k - 4));
    return acc;
  endfunction

  // returns 0 for a pulse the decoder drops outside a session
  function automatic bit advance_decoder(input logic func, input logic [15:0] dur,
                                         output bit fired, output dcf_pkg::dcf_time_t res);
    int unsigned mi, hr, dm, wd, mo, yr;
    fired = 1'b0;
    res = NO_TIME;
    if (func == dcf_pkg::FUNC_START) begin
      in_session = 1'b1;
      next_bit = '0;
      locked = 1'b0;
      rx_frame = '0;
      pulse_total = '0;
      return 1'b1;
    end
    if (!in_session) return 1'b0;
    if (dur > marker_ms) begin
      next_bit = '0;
      locked = 1'b1;
      rx_frame = '0;
    end else if (locked) begin
      if (dur >= one_min_ms && dur < zero_min_ms) begin
        rx_frame[next_bit] = 1'b1;
        next_bit++;
      end else if (dur >= zero_min_ms && dur < zero_max_ms) begin
        next_bit++;
      end else begin
        locked = 1'b0;
      end
    end
    if (pulse_total != dcf_pkg::COUNT_MAX) pulse_total++;
    if (pulse_total > pulse_limit) begin
      in_session = 1'b0;
      fired = 1'b1;
      res = TIMED_OUT;
      return 1'b1;
    end
    if (locked && next_bit == dcf_pkg::FRAME_DONE) begin
      mi = field_value(dcf_pkg::MIN_LSB, 7);
      hr = field_value(dcf_pkg::HOUR_LSB, 6);
      dm = field_value(dcf_pkg::DAY_LSB, 6);
      wd = field_value(dcf_pkg::WDAY_LSB, 3);
      mo = field_value(dcf_pkg::MON_LSB, 5);
      yr = field_value(dcf_pkg::YEAR_LSB, 8);
      in_session = 1'b0;
      fired = 1'b1;
      res.status = (mi < 60 && hr < 24 && wd <= 7 && dm <= 31 && mo <= 12 && yr < 100) ?
                   dcf_pkg::STATUS_VALID : dcf_pkg::STATUS_RANGE;
      res.minutes = 7'(mi);
      res.hours = 6'(hr);
      res.mday = 6'(dm);
      res.wday = 3'(wd);
      res.month_num = 5'(mo);
      res.year_two_digit = 8'(yr);
    end
    return 1'b1;
  endfunction

  function automatic logic [dcf_pkg::FRAME_W-1:0] place_bcd(
      input logic [dcf_pkg::FRAME_W-1:0] f, input int lsb, input int n, input int unsigned v);
    logic [7:0] digits;
    digits = {4'(v / 10), 4'(v % 10)};
    for (int k = 0; k < n; k++) f[lsb + k] = digits[k];
    return f;
  endfunction

  function automatic logic [dcf_pkg::FRAME_W-1:0] pick_frame(input bit sane);
    logic [63:0] raw;
    logic [dcf_pkg::FRAME_W-1:0] f;
    raw = {$urandom, $urandom};
    f = raw[dcf_pkg::FRAME_W-1:0];
    if (sane) begin
      f = place_bcd(f, dcf_pkg::MIN_LSB, 7, $urandom_range(59));
      f = place_bcd(f, dcf_pkg::HOUR_LSB, 6, $urandom_range(23));
      f = place_bcd(f, dcf_pkg::DAY_LSB, 6, $urandom_range(31, 1));
      f = place_bcd(f, dcf_pkg::WDAY_LSB, 3, $urandom_range(7, 1));
      f = place_bcd(f, dcf_pkg::MON_LSB, 5, $urandom_range(12, 1));
      f = place_bcd(f, dcf_pkg::YEAR_LSB, 8, $urandom_range(99));
    end
    return f;
  endfunction

  function automatic logic [15:0] marker_pick();
    if (marker_ms == 16'hFFFF) return 16'($urandom);
    if ($urandom_range(3) == 0) return marker_ms + 16'd1;
    return 16'($urandom_range(65535, 32'(marker_ms) + 1));
  endfunction

  // favor the window edges
  function automatic logic [15:0] window_pick(input logic [15:0] lo, input logic [15:0] hi);
    if (lo >= hi) return 16'($urandom);
    case ($urandom_range(3))
      0: return lo;
      1: return hi - 16'd1;
      default: return 16'($urandom_range(32'(hi) - 1, lo));
    endcase
  endfunction

  function automatic logic [15:0] bit_pick(input logic one);
    return one ? window_pick(one_min_ms, zero_min_ms) : window_pick(zero_min_ms, zero_max_ms);
  endfunction

  function automatic logic [15:0] any_pick();
    case ($urandom_range(3))
      0: return marker_pick();
      1: return bit_pick(1'b1);
      2: return bit_pick(1'b0);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void cmp_field(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_times.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, out_status);
        err_count++;
      end else begin
        head_time = expected_times.pop_front();
        cmp_field("status", head_time.status, out_status);
        cmp_field("minutes", head_time.minutes, out_minutes);
        cmp_field("hours", head_time.hours, out_hours);
        cmp_field("mday", head_time.mday, out_mday);
        cmp_field("wday", head_time.wday, out_wday);
        cmp_field("month_num", head_time.month_num, out_month_num);
        cmp_field("year_two_digit", head_time.year_two_digit, out_year_two_digit);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req != 0) begin
        stall_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // hold the beat until accepted; valid stays high afterwards
  task automatic offer_beat(input logic func, input logic [15:0] dur);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_low_duration <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_beat(input logic func, input logic [15:0] dur);
    bit fired;
    dcf_pkg::dcf_time_t t;
    offer_beat(func, dur);
    if (advance_decoder(func, dur, fired, t)) live_items++;
    if (fired) begin
      expected_times.push_back(t);
      times_due++;
    end
  endtask

  // drain results, then give the last beat time to clear the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dcf_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dcf_pkg::REG_ONE_LOW_MIN:    one_min_ms = val;
      dcf_pkg::REG_ZERO_LOW_MIN:   zero_min_ms = val;
      dcf_pkg::REG_ZERO_LOW_MAX:   zero_max_ms = val;
      dcf_pkg::REG_MARKER_ABOVE:   marker_ms = val;
      dcf_pkg::REG_WATCHDOG_LIMIT: pulse_limit = val[dcf_pkg::WDOG_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_thresholds(input logic [15:0] one, input logic [15:0] zero,
                                 input logic [15:0] zmax, input logic [15:0] mark,
                                 input logic [dcf_pkg::WDOG_W-1:0] wd);
    write_reg(dcf_pkg::REG_ONE_LOW_MIN, one);
    write_reg(dcf_pkg::REG_ZERO_LOW_MIN, zero);
    write_reg(dcf_pkg::REG_ZERO_LOW_MAX, zmax);
    write_reg(dcf_pkg::REG_MARKER_ABOVE, mark);
    write_reg(dcf_pkg::REG_WATCHDOG_LIMIT, 16'(wd));
  endtask

  task automatic pick_thresholds();
    int unsigned a, b, c, m, r;
    r = $urandom_range(99);
    if (r < 15) begin
      load_thresholds(dcf_pkg::ONE_LOW_MIN_RST, dcf_pkg::ZERO_LOW_MIN_RST,
                      dcf_pkg::ZERO_LOW_MAX_RST, dcf_pkg::MARKER_ABOVE_RST,
                      9'($urandom_range(510, 60)));
    end else if (r < 25) begin
      load_thresholds(16'd0, 16'd1, 16'd2, 16'd3, 9'($urandom_range(510, 60)));
    end else if (r < 80) begin
      a = $urandom_range(60000);
      b = a + $urandom_range(1500, 1);
      c = b + $urandom_range(1500, 1);
      m = c - 1 + $urandom_range(1500);
      load_thresholds(16'(a), 16'(b), 16'(c), 16'(m), 9'($urandom_range(510)));
    end else begin
      load_thresholds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      9'($urandom_range(510)));
    end
  endtask

  // start, stray pulses, marker, 58 bits; a noise pulse lands before bit break_at
  task automatic run_frame(input logic [dcf_pkg::FRAME_W-1:0] bits, input int junk,
                           input int break_at);
    send_beat(dcf_pkg::FUNC_START, 16'($urandom));
    repeat (junk) send_beat(dcf_pkg::FUNC_PULSE, 16'($urandom));
    send_beat(dcf_pkg::FUNC_PULSE, marker_pick());
    for (int i = 0; i < dcf_pkg::FRAME_W; i++) begin
      if (i == break_at) send_beat(dcf_pkg::FUNC_PULSE, 16'($urandom));
      send_beat(dcf_pkg::FUNC_PULSE, bit_pick(bits[i]));
    end
  endtask

  task automatic pace_for(input int done);
    if (done < ITEM_GOAL / 3) begin
      tx_idle_pct = 27;
      rx_idle_pct = 61;
    end else if (done < 2 * ITEM_GOAL / 3) begin
      tx_idle_pct = 61;
      rx_idle_pct = 27;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  initial begin : stimulus
    bit fired;
    dcf_pkg::dcf_time_t t;
    int rand_base, due_base, session_no, roll, drain;

    directed_rows = '{
      '{dcf_pkg::FUNC_PULSE, 16'd0,     1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd65535, 1'b0, NO_TIME},
      '{dcf_pkg::FUNC_START, 16'd65535, 1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd1200,  1'b0, NO_TIME},
      '{dcf_pkg::FUNC_START, 16'd0,     1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd1501,  1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd750,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd849,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd850,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd949,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd1500,  1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd800,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd65535, 1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd749,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd1501,  1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd0,     1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd950,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_PULSE, 16'd900,   1'b1, TIMED_OUT},
      '{dcf_pkg::FUNC_PULSE, 16'd900,   1'b0, NO_TIME},
      '{dcf_pkg::FUNC_START, 16'd0,     1'b0, NO_TIME}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pace_for(0);
    // thirteenth pulse after the restart trips the watchdog
    write_reg(dcf_pkg::REG_WATCHDOG_LIMIT, 16'd12);
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_beat(directed_rows[r].func, directed_rows[r].dur);
      if (advance_decoder(directed_rows[r].func, directed_rows[r].dur, fired, t)) live_items++;
      if (directed_rows[r].typed) begin
        expected_times.push_back(directed_rows[r].want);
        times_due++;
      end else if (fired) begin
        expected_times.push_back(t);
        times_due++;
      end
    end

    rand_base = live_items;
    due_base = times_due;

    // full frames: all zero, all ones, a real time, then one that also trips the watchdog
    settle();
    load_thresholds(dcf_pkg::ONE_LOW_MIN_RST, dcf_pkg::ZERO_LOW_MIN_RST,
                    dcf_pkg::ZERO_LOW_MAX_RST, dcf_pkg::MARKER_ABOVE_RST, 9'd59);
    run_frame('0, 0, -1);
    run_frame('1, 0, -1);
    run_frame(pick_frame(1'b1), 0, -1);
    settle();
    write_reg(dcf_pkg::REG_WATCHDOG_LIMIT, 16'd58);
    run_frame(pick_frame(1'b1), 0, -1);

    // back up the result side: every start/pulse pair times out at once
    settle();
    load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 9'd0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    sink_hold_req = 300;
    repeat (40) begin
      send_beat(dcf_pkg::FUNC_START, 16'($urandom));
      send_beat(dcf_pkg::FUNC_PULSE, 16'($urandom));
    end

    // no marker possible; the session only ends on the widest watchdog
    settle();
    pace_for(live_items - rand_base);
    load_thresholds(16'd65533, 16'd65534, 16'd65535, 16'd65535, 9'd510);
    send_beat(dcf_pkg::FUNC_START, 16'd0);
    repeat (515) send_beat(dcf_pkg::FUNC_PULSE, any_pick());

    session_no = 0;
    while (live_items - rand_base < ITEM_GOAL || times_due - due_base < 48) begin
      pace_for(live_items - rand_base);
      if (session_no % 5 == 0) begin
        settle();
        pick_thresholds();
      end
      roll = $urandom_range(99);
      if (roll < 70) begin
        run_frame(pick_frame($urandom_range(1)), $urandom_range(3), -1);
      end else if (roll < 85) begin
        run_frame(pick_frame($urandom_range(1)), $urandom_range(3),
                  $urandom_range(dcf_pkg::FRAME_W - 1));
      end else if (roll < 95) begin
        send_beat(dcf_pkg::FUNC_START, 16'($urandom));
        repeat ($urandom_range(30, 1)) send_beat(dcf_pkg::FUNC_PULSE, any_pick());
      end else begin
        repeat ($urandom_range(8, 1)) send_beat(dcf_pkg::FUNC_PULSE, any_pick());
      end
      session_no++;
    end

    in_valid <= 1'b0;
    drain = 0;
    while (expected_times.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (expected_times.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_times.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
